[design/history_prioritized_channel_scan_unit_defines.svh]
// ----------------------------------------------------------------------------
// Scan unit assertion macros
// Shared concurrent assertion forms for the channel scan unit.
// ----------------------------------------------------------------------------
`ifndef HISTORY_PRIORITIZED_CHANNEL_SCAN_UNIT_DEFINES_SVH
`define HISTORY_PRIORITIZED_CHANNEL_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HPCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hpcs_pkg.sv]
// ----------------------------------------------------------------------------
// Scan unit package
// Widths, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package hpcs_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CNT_W        = CH_W + 1;   // channel count, scan step, fill count
    localparam int SNR_W        = 16;
    localparam int DWELL_W      = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int OP_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ASSOC   = 2'd0,
        OP_DEASSOC = 2'd1,
        OP_BEACON  = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS     = 2'd2;

    localparam logic ACT_TUNE = 1'b0;
    localparam logic ACT_DONE = 1'b1;

    localparam logic [CNT_W-1:0]   RST_CHANNEL_COUNT   = 5'd16;
    localparam logic [CH_W-1:0]    RST_INITIAL_CHANNEL = 4'd0;
    localparam logic [DWELL_W-1:0] RST_DWELL_TICKS     = 16'd150;
    localparam logic [DWELL_W-1:0] DWELL_MAX           = '1;

endpackage

[design/hpcs_ram.sv]
// ----------------------------------------------------------------------------
// Scan unit RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpcs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/history_prioritized_channel_scan_unit.sv]
// Busy periods: a beacon passes through S_HIST; a tick that ends a dwell goes to S_EMIT
//   for a finish result, or through S_FETCH and S_EMIT for a tune result.
// Deassociation: one selection pass per channel with history (at most 15), one more
//   pass that finds none, then S_FILL, S_LAST, S_FETCH and S_EMIT to the first tune.
// Throughput: one transfer per busy period above, plus any wait on the output reg.
// Reset: synchronous, active low; registers to defaults, history valid bits clear.
// ----------------------------------------------------------------------------
// History prioritized channel scan unit
// Roaming scan controller: orders channels by beacon history, dwells on each,
// and reports the best channel at the end of a scan.
// ----------------------------------------------------------------------------
`include "history_prioritized_channel_scan_unit_defines.svh"

module history_prioritized_channel_scan_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [hpcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpcs_pkg::CFG_W-1:0]           i_cfg_data,
    // event channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [hpcs_pkg::OP_W-1:0]            i_operation,
    input  logic signed [hpcs_pkg::SNR_W-1:0]    i_snr,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_action,
    output logic [hpcs_pkg::CH_W-1:0]            o_channel,
    output logic                                 o_beacon_found,
    output logic signed [hpcs_pkg::SNR_W-1:0]    o_best_snr
);

    import hpcs_pkg::*;

    // S_PASS : one selection pass over the history RAM, picks the best
    //          unpicked channel with history (ties to the lower index)
    // S_FILL : appends channels without history in index order
    // S_LAST : appends the current channel
    // S_FETCH: reads scan_order[step]; S_EMIT loads the result register
    // S_HIST : read-modify-write of the history entry for a beacon
    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_FILL,
        S_LAST,
        S_FETCH,
        S_EMIT,
        S_HIST
    } t_state;

    t_state r_state;

    // configuration
    logic [CNT_W-1:0]   r_channel_count;
    logic [DWELL_W-1:0] r_dwell_ticks;

    // scan control
    logic               r_scanning;
    logic [CNT_W-1:0]   r_step;
    logic [CNT_W-1:0]   r_len;
    logic [CH_W-1:0]    r_ch;        // scan_order[step], channel of the dwell
    logic [CH_W-1:0]    r_cur;       // current channel
    logic [MAX_CHANNELS-1:0] r_hv;   // history valid bits

    logic                     r_dv;
    logic signed [SNR_W-1:0]  r_ds;
    logic [DWELL_W-1:0]       r_count;
    logic                     r_bv;
    logic signed [SNR_W-1:0]  r_bl;
    logic [CH_W-1:0]          r_best_ch;

    // order build
    logic [CNT_W-1:0]         r_idx;     // read issue index / fill index
    logic                     r_p_vld;   // history read data valid this cycle
    logic [CH_W-1:0]          r_p_idx;   // index of that read data
    logic [MAX_CHANNELS-1:0]  r_taken;
    logic [CNT_W-1:0]         r_n;       // entries written to the order RAM
    logic                     r_sel_found;
    logic [CH_W-1:0]          r_sel_idx;
    logic signed [SNR_W-1:0]  r_sel_snr;

    logic                     r_fin;     // pending result is a finish
    logic signed [SNR_W-1:0]  r_snr;     // beacon SNR held for the history update

    // result register
    logic                     r_out_vld;
    logic                     r_out_action;
    logic [CH_W-1:0]          r_out_ch;
    logic                     r_out_found;
    logic signed [SNR_W-1:0]  r_out_snr;

    // RAM ports
    logic                     hist_we;
    logic [CH_W-1:0]          hist_raddr;
    logic [SNR_W-1:0]         hist_q_raw;
    logic signed [SNR_W-1:0]  hist_q;
    logic                     ord_we;
    logic [CH_W-1:0]          ord_waddr;
    logic [CH_W-1:0]          ord_wdata;
    logic [CH_W-1:0]          ord_q;

    logic                     accept;
    logic [CNT_W-1:0]         limit;
    logic                     p_cand;
    logic                     p_take;
    logic                     pass_last;
    logic                     n_sel_found;
    logic [CH_W-1:0]          n_sel_idx;
    logic signed [SNR_W-1:0]  n_sel_snr;
    logic [CH_W-1:0]          f_idx;
    logic                     f_cand;
    logic [DWELL_W-1:0]       n_count;
    logic                     dwell_done;
    logic                     better;
    logic [CH_W-1:0]          n_best_ch;
    logic [CNT_W-1:0]         n_step;
    logic                     dwell_take;
    logic                     out_free;
    logic                     emit_go;

    // Events are taken only between busy periods; a result still waiting in
    // the output register does not hold off the next event.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign emit_go    = (r_state == S_EMIT) && out_free;

    // Counts above the channel table size act as the table size.
    assign limit = (r_channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                            : r_channel_count;

    // Selection pass: a channel qualifies if it has history, is in the list,
    // is not the current channel and was not picked in an earlier pass.
    // Strictly greater replaces, so equal SNRs keep the lower index.
    assign p_cand = r_p_vld && r_hv[r_p_idx] && (r_p_idx != r_cur)
                    && ({1'b0, r_p_idx} < limit) && !r_taken[r_p_idx];
    assign p_take = p_cand && (!r_sel_found || (hist_q > r_sel_snr));
    assign n_sel_found = r_sel_found || p_take;
    assign n_sel_idx   = p_take ? r_p_idx : r_sel_idx;
    assign n_sel_snr   = p_take ? hist_q  : r_sel_snr;
    assign pass_last   = r_p_vld && (r_p_idx == CH_W'(MAX_CHANNELS - 1));

    // Fill sweep: channels without history in index order.
    assign f_idx  = r_idx[CH_W-1:0];
    assign f_cand = !r_hv[f_idx] && (f_idx != r_cur) && ({1'b0, f_idx} < limit);

    // Tick: saturating dwell counter; a zero dwell acts as one tick.
    assign n_count    = (r_count == DWELL_MAX) ? r_count : r_count + DWELL_W'(1);
    assign dwell_done = (n_count >= r_dwell_ticks);
    assign better     = r_dv && (!r_bv || (r_ds > r_bl));
    assign n_best_ch  = better ? r_ch : r_best_ch;
    assign n_step     = r_step + CNT_W'(1);

    // Beacon: best SNR within the dwell, strictly greater replaces.
    assign dwell_take = !r_dv || (i_snr > r_ds);

    // History RAM: swept during the passes, otherwise it reads the entry of
    // the dwell channel so the registered entry is ready for the beacon update. Writes
    // happen only in S_HIST, which always returns to S_IDLE, so a read never
    // overlaps a pending write to the same entry.
    assign hist_raddr = (r_state == S_PASS) ? r_idx[CH_W-1:0] : r_ch;
    assign hist_we    = (r_state == S_HIST) && (!r_hv[r_ch] || (r_snr > hist_q));
    assign hist_q     = $signed(hist_q_raw);

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_n[CH_W-1:0];
        ord_wdata = r_cur;
        unique case (r_state)
            S_PASS: begin
                ord_we    = pass_last && n_sel_found;
                ord_wdata = n_sel_idx;
            end
            S_FILL: begin
                ord_we    = f_cand;
                ord_wdata = f_idx;
            end
            S_LAST: begin
                ord_we    = 1'b1;
                ord_wdata = r_cur;
            end
            default: begin
                ord_we    = 1'b0;
            end
        endcase
    end

    hpcs_ram #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (SNR_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_ch),
        .i_wdata (r_snr),
        .i_raddr (hist_raddr),
        .o_rdata (hist_q_raw)
    );

    // At most MAX_CHANNELS entries: the current channel is excluded from
    // the list part, and S_LAST appends it once at the end.
    hpcs_ram #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (CH_W)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (r_step[CH_W-1:0]),
        .o_rdata (ord_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_dwell_ticks   <= RST_DWELL_TICKS;
            r_cur           <= RST_INITIAL_CHANNEL;
            r_scanning      <= 1'b0;
            r_step          <= '0;
            r_len           <= '0;
            r_hv            <= '0;
            r_dv            <= 1'b0;
            r_ds            <= '0;
            r_count         <= '0;
            r_bv            <= 1'b0;
            r_bl            <= '0;
            r_best_ch       <= '0;
            r_idx           <= '0;
            r_p_vld         <= 1'b0;
            r_taken         <= '0;
            r_n             <= '0;
            r_sel_found     <= 1'b0;
            r_fin           <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            // a new result loads the register, else a transfer drains it
            if (emit_go) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (t_op'(i_operation))
                            OP_ASSOC: begin
                                r_scanning <= 1'b0;
                            end
                            OP_DEASSOC: begin
                                if (!r_scanning) begin
                                    r_scanning  <= 1'b1;
                                    r_bv        <= 1'b0;
                                    r_bl        <= '0;
                                    r_best_ch   <= r_cur;
                                    r_step      <= '0;
                                    r_dv        <= 1'b0;
                                    r_ds        <= '0;
                                    r_count     <= '0;
                                    r_taken     <= '0;
                                    r_n         <= '0;
                                    r_idx       <= '0;
                                    r_p_vld     <= 1'b0;
                                    r_sel_found <= 1'b0;
                                    r_state     <= S_PASS;
                                end
                            end
                            OP_BEACON: begin
                                if (r_scanning) begin
                                    if (dwell_take) begin
                                        r_dv <= 1'b1;
                                        r_ds <= i_snr;
                                    end
                                    r_snr   <= i_snr;
                                    r_state <= S_HIST;
                                end
                            end
                            OP_TICK: begin
                                if (r_scanning) begin
                                    if (dwell_done) begin
                                        if (better) begin
                                            r_bv <= 1'b1;
                                            r_bl <= r_ds;
                                        end
                                        r_best_ch <= n_best_ch;
                                        r_step    <= n_step;
                                        r_dv      <= 1'b0;
                                        r_ds      <= '0;
                                        r_count   <= '0;
                                        if (n_step >= r_len) begin
                                            r_scanning <= 1'b0;
                                            r_cur      <= n_best_ch;
                                            r_fin      <= 1'b1;
                                            r_state    <= S_EMIT;
                                        end else begin
                                            r_fin   <= 1'b0;
                                            r_state <= S_FETCH;
                                        end
                                    end else begin
                                        r_count <= n_count;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_PASS: begin
                    r_p_idx   <= r_idx[CH_W-1:0];
                    r_sel_idx <= n_sel_idx;
                    r_sel_snr <= n_sel_snr;
                    if (pass_last) begin
                        r_idx   <= '0;
                        r_p_vld <= 1'b0;
                        if (n_sel_found) begin
                            // winner written to the order RAM; next pass
                            r_taken[n_sel_idx] <= 1'b1;
                            r_n                <= r_n + CNT_W'(1);
                            r_sel_found        <= 1'b0;
                        end else begin
                            r_state <= S_FILL;
                        end
                    end else begin
                        if (!r_idx[CNT_W-1]) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                        r_p_vld     <= !r_idx[CNT_W-1];
                        r_sel_found <= n_sel_found;
                    end
                end

                S_FILL: begin
                    if (f_cand) begin
                        r_n <= r_n + CNT_W'(1);
                    end
                    r_idx <= r_idx + CNT_W'(1);
                    if (f_idx == CH_W'(MAX_CHANNELS - 1)) begin
                        r_state <= S_LAST;
                    end
                end

                S_LAST: begin
                    r_len   <= r_n + CNT_W'(1);
                    r_fin   <= 1'b0;
                    r_state <= S_FETCH;
                end

                S_FETCH: begin
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        if (r_fin) begin
                            r_out_action <= ACT_DONE;
                            r_out_ch     <= r_best_ch;
                            r_out_found  <= r_bv;
                            r_out_snr    <= r_bv ? r_bl : '0;
                        end else begin
                            r_out_action <= ACT_TUNE;
                            r_out_ch     <= ord_q;
                            r_out_found  <= 1'b0;
                            r_out_snr    <= '0;
                            r_ch         <= ord_q;
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_HIST: begin
                    if (hist_we) begin
                        r_hv[r_ch] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // configuration writes must arrive only while idle; the block does not enforce this
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHANNEL_COUNT:   r_channel_count <= i_cfg_data[CNT_W-1:0];
                    CFG_INITIAL_CHANNEL: r_cur           <= i_cfg_data[CH_W-1:0];
                    CFG_DWELL_TICKS:     r_dwell_ticks   <= i_cfg_data[DWELL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_action       = r_out_action;
    assign o_channel      = r_out_ch;
    assign o_beacon_found = r_out_found;
    assign o_best_snr     = r_out_snr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic tune_out;
    logic tune_zero;
    logic done_none;
    logic snr_zero;
    logic scan_idle;
    logic len_ok;

    assign snr_zero  = (o_best_snr == '0);
    assign tune_out  = o_out_valid && (o_action == ACT_TUNE);
    assign tune_zero = !o_beacon_found && snr_zero;
    assign done_none = o_out_valid && (o_action == ACT_DONE) && !o_beacon_found;
    assign scan_idle = r_scanning && (r_state == S_IDLE);
    assign len_ok    = !r_len[CNT_W-1] || (r_len == CNT_W'(MAX_CHANNELS));

    `HPCS_ASSERT_IMPLY(a_tune_clear, i_clk, i_rst_n, tune_out, tune_zero, "tune with finish fields")
    `HPCS_ASSERT_IMPLY(a_done_snr, i_clk, i_rst_n, done_none, snr_zero, "finish SNR without beacon")
    `HPCS_ASSERT_IMPLY(a_step_in_range, i_clk, i_rst_n, scan_idle, r_step < r_len, "step past order")
    `HPCS_ASSERT_NEXT(a_order_fits, i_clk, i_rst_n, r_state == S_LAST, len_ok, "order overflow")

endmodule
